// ===== src/dqsf_pkg.sv =====
// Shared types and constants for the dual quadrature speed filter.
`timescale 1ns / 1ps

package dqsf_pkg;

	// Fixed field widths
	localparam int SAMP_W   = 16;
	localparam int FILT_W   = 24;
	localparam int DIST_W   = 48;
	localparam int WEIGHT_W = 9;

	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd154;

	localparam logic signed [FILT_W-1:0] FILT_MAX_V = 24'sh7FFFFF;
	localparam logic signed [FILT_W-1:0] FILT_MIN_V = 24'sh800000;

	// Item command codes
	localparam logic CMD_EDGE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Pin bit positions
	localparam int PIN_RA = 0;
	localparam int PIN_RB = 1;
	localparam int PIN_LA = 2;
	localparam int PIN_LB = 3;

	typedef struct packed {
		logic       cmd;
		logic [3:0] pin_flags;
		logic [3:0] pin_levels;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMP_W-1:0] left_sampled;
		logic signed [SAMP_W-1:0] right_sampled;
		logic signed [FILT_W-1:0] filtered_average;
		logic signed [DIST_W-1:0] distance_total;
	} out_item_t;

	// Per-lane control from the top level
	typedef struct packed {
		logic step;  // edge item moves this counter
		logic up;    // direction of that move
		logic tick;  // sample tick accepted: latch and clear
		logic adv;   // stage 1 moves into stage 2 (filter update)
	} lane_ctl_t;

endpackage

// ===== src/dqsf_lane.sv =====
// One wheel lane: saturating quadrature counter, sample latch and EMA filter.
`timescale 1ns / 1ps

module dqsf_lane #(
	parameter int COUNT_BITS       = 16,
	parameter int WEIGHT_FRAC_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dqsf_pkg::lane_ctl_t                 ctl,
	input  logic [dqsf_pkg::WEIGHT_W-1:0]       weight,
	output logic signed [COUNT_BITS-1:0]        raw_s2,
	output logic signed [dqsf_pkg::FILT_W-1:0]  filt_q
);
	import dqsf_pkg::*;

	localparam logic signed [COUNT_BITS-1:0] CMAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
	localparam logic signed [COUNT_BITS-1:0] CMIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

	localparam logic [31:0] ONE = 32'(1) << WEIGHT_FRAC_BITS;
	localparam int WCW = (WEIGHT_FRAC_BITS + 1 < WEIGHT_W) ? WEIGHT_FRAC_BITS + 1 : WEIGHT_W;
	localparam int RSW = COUNT_BITS + WEIGHT_FRAC_BITS;
	localparam int DW  = ((RSW > FILT_W) ? RSW : FILT_W) + 1;
	localparam int PW  = WCW + 1 + DW;
	localparam int SW  = PW + 1;

	logic signed [COUNT_BITS-1:0] count_q;
	logic signed [COUNT_BITS-1:0] raw_s1;

	logic [31:0]           wc32;
	logic [WCW-1:0]        wc;
	logic signed [WCW:0]   wcs;
	logic signed [DW-1:0]  raw_sh;
	logic signed [DW-1:0]  diff;
	logic signed [PW-1:0]  prod;
	logic signed [SW-1:0]  sum;
	logic signed [FILT_W-1:0] filt_new;

	// Counter: saturating step on edges, cleared by a tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.tick) begin
			count_q <= '0;
		end else if (ctl.step) begin
			if (ctl.up) begin
				count_q <= (count_q == CMAX) ? CMAX : count_q + 1'b1;
			end else begin
				count_q <= (count_q == CMIN) ? CMIN : count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.tick) begin
			raw_s1 <= count_q;
		end
		if (ctl.adv) begin
			raw_s2 <= raw_s1;
		end
	end

	// new = old + floor(w * (raw*one - old) / one)
	always_comb begin
		wc32     = (32'(weight) > ONE) ? ONE : 32'(weight);
		wc       = wc32[WCW-1:0];
		wcs      = {1'b0, wc};
		raw_sh   = DW'(raw_s1) <<< WEIGHT_FRAC_BITS;
		diff     = raw_sh - DW'(filt_q);
		prod     = PW'(wcs) * PW'(diff);
		sum      = SW'(filt_q) + SW'(prod >>> WEIGHT_FRAC_BITS);
		if (sum > SW'(FILT_MAX_V)) begin
			filt_new = FILT_MAX_V;
		end else if (sum < SW'(FILT_MIN_V)) begin
			filt_new = FILT_MIN_V;
		end else begin
			filt_new = sum[FILT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q <= '0;
		end else if (ctl.adv) begin
			filt_q <= filt_new;
		end
	end

endmodule

// ===== src/dqsf_merge.sv =====
// Merge stage: averages the two filtered values and keeps the distance total.
`timescale 1ns / 1ps

module dqsf_merge (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  logic signed [dqsf_pkg::SAMP_W-1:0] left_raw,
	input  logic signed [dqsf_pkg::SAMP_W-1:0] right_raw,
	input  logic signed [dqsf_pkg::FILT_W-1:0] left_filt,
	input  logic signed [dqsf_pkg::FILT_W-1:0] right_filt,
	output dqsf_pkg::out_item_t                out_q
);
	import dqsf_pkg::*;

	logic signed [FILT_W:0]   pair_sum;
	logic signed [FILT_W-1:0] avg;
	logic signed [DIST_W-1:0] dist_q;
	logic signed [DIST_W-1:0] dist_next;

	always_comb begin
		pair_sum  = (FILT_W+1)'(left_filt) + (FILT_W+1)'(right_filt);
		avg       = FILT_W'(pair_sum >>> 1);
		dist_next = dist_q + DIST_W'(avg);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= '0;
		end else if (adv) begin
			dist_q <= dist_next;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.left_sampled     <= left_raw;
			out_q.right_sampled    <= right_raw;
			out_q.filtered_average <= avg;
			out_q.distance_total   <= dist_next;
		end
	end

endmodule

// ===== src/dual_quadrature_speed_filter.sv =====
// A tick result passes stage 1, stage 2 and the output register (3-stage pipe).
// Throughput: one item per cycle while not stalled; edge items produce no result and
// never stall downstream. Input stalls only when all three stages hold tick results
// and the output is stalled. Reset (arst_n low, async): counters, filters, distance
// total and valids clear; filter weight returns to 154. No clearing pass.
`timescale 1ns / 1ps

module dual_quadrature_speed_filter #(
	parameter int COUNT_BITS       = 16,
	parameter int WEIGHT_FRAC_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_wr_en,
	input  logic [dqsf_pkg::WEIGHT_W-1:0]     cfg_wr_data,
	// pin event / tick items
	input  logic                              event_valid,
	output logic                              event_stall,
	input  dqsf_pkg::in_item_t                event_item,
	// result items
	output logic                              result_valid,
	input  logic                              result_stall,
	output dqsf_pkg::out_item_t               result_item
);
	import dqsf_pkg::*;

	// Pipeline:
	//   accept : counters step on edge items; a tick latches both counts
	//            into stage 1 and clears the counters in the same edge.
	//   s1->s2 : both lanes run their EMA update (one multiply each).
	//   s2->out: merge averages the filters and adds into the distance total.
	// Each stage moves when the one after it is empty or moving, so bubbles
	// collapse and items keep coming while a result waits at the output.

	logic [WEIGHT_W-1:0] weight_q;

	logic s1_v_q;
	logic s2_v_q;
	logic res_v_q;

	logic out_free;
	logic s2_adv;
	logic s2_free;
	logic s1_adv;
	logic s1_free;
	logic accept;
	logic tick;
	logic edge_ev;

	lane_ctl_t right_ctl;
	lane_ctl_t left_ctl;

	logic signed [COUNT_BITS-1:0] right_raw_s2;
	logic signed [COUNT_BITS-1:0] left_raw_s2;
	logic signed [FILT_W-1:0]     right_filt_q;
	logic signed [FILT_W-1:0]     left_filt_q;

	// Filter weight register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= WEIGHT_RESET;
		end else if (cfg_wr_en) begin
			weight_q <= cfg_wr_data;
		end
	end

	// Elastic stage control
	always_comb begin
		out_free    = !res_v_q || !result_stall;
		s2_adv      = s2_v_q && out_free;
		s2_free     = !s2_v_q || out_free;
		s1_adv      = s1_v_q && s2_free;
		s1_free     = !s1_v_q || s2_free;
		event_stall = !s1_free;
		accept      = event_valid && s1_free;
		tick        = accept && (event_item.cmd == CMD_TICK);
		edge_ev     = accept && (event_item.cmd == CMD_EDGE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			s2_v_q  <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			s1_v_q  <= tick || (s1_v_q && !s1_adv);
			s2_v_q  <= s1_adv || (s2_v_q && !s2_adv);
			res_v_q <= s2_adv || (res_v_q && result_stall);
		end
	end

	// Quadrature decode. Pin A is tested first; pin B only when A is not flagged.
	// Right: A edge counts up when B is high; B edge counts up when A is low.
	// Left : A edge counts up when B is low;  B edge counts up when A is high.
	always_comb begin
		right_ctl.tick = tick;
		right_ctl.adv  = s1_adv;
		left_ctl.tick  = tick;
		left_ctl.adv   = s1_adv;

		right_ctl.step = edge_ev &&
			(event_item.pin_flags[PIN_RA] || event_item.pin_flags[PIN_RB]);
		right_ctl.up   = event_item.pin_flags[PIN_RA] ? event_item.pin_levels[PIN_RB]
		                                              : !event_item.pin_levels[PIN_RA];

		left_ctl.step  = edge_ev &&
			(event_item.pin_flags[PIN_LA] || event_item.pin_flags[PIN_LB]);
		left_ctl.up    = event_item.pin_flags[PIN_LA] ? !event_item.pin_levels[PIN_LB]
		                                              : event_item.pin_levels[PIN_LA];
	end

	dqsf_lane #(
		.COUNT_BITS       (COUNT_BITS),
		.WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
	) u_lane_right (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (right_ctl),
		.weight (weight_q),
		.raw_s2 (right_raw_s2),
		.filt_q (right_filt_q)
	);

	dqsf_lane #(
		.COUNT_BITS       (COUNT_BITS),
		.WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
	) u_lane_left (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (left_ctl),
		.weight (weight_q),
		.raw_s2 (left_raw_s2),
		.filt_q (left_filt_q)
	);

	// filt_q in each lane doubles as stage-2 data: it only changes when
	// stage 2 is empty or handing its value to the merge in the same edge.
	dqsf_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (s2_adv),
		.left_raw   (SAMP_W'(left_raw_s2)),
		.right_raw  (SAMP_W'(right_raw_s2)),
		.left_filt  (left_filt_q),
		.right_filt (right_filt_q),
		.out_q      (result_item)
	);

	assign result_valid = res_v_q;

endmodule

// ===== src/dqsf_checker.sv =====
// Port-level checks for the dual quadrature speed filter, bound to the top level.
`timescale 1ns / 1ps

module dqsf_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                event_stall,
	input logic                result_valid,
	input logic                result_stall,
	input dqsf_pkg::out_item_t result_item
);
	import dqsf_pkg::*;

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> result_valid)
		else $error("result_valid dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> $stable(result_item))
		else $error("result item changed while stalled");

	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !event_stall)
		else $error("input stalled with empty output");

	a_distance_step: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_stall && $past(result_valid && !result_stall))
		|-> (result_item.distance_total ==
		     $past(result_item.distance_total) + DIST_W'(result_item.filtered_average)))
		else $error("distance total does not follow filtered average");

endmodule

bind dual_quadrature_speed_filter dqsf_checker u_dqsf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.event_stall  (event_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result_item  (result_item)
);

// ===== sim/dual_quadrature_speed_filter_tb.sv =====
// Self-checking testbench for the dual quadrature speed filter.
`timescale 1ns / 1ps

module dual_quadrature_speed_filter_tb;
	import dqsf_pkg::*;

	localparam int     FRAC_BITS   = 8;
	localparam longint WEIGHT_ONE  = longint'(1) << FRAC_BITS;
	localparam int     LONG_RUN    = 40;     // one-direction edge run length
	localparam int     RANDOM_RUN  = 150;
	localparam int     SETTLE      = 6;      // pipe is 3 deep; a few spare cycles
	localparam int     IDLE_LIMIT  = 4000;   // cycles with no handshake at all

	// DUT ports; the inputs are known from time zero
	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                cfg_wr_en    = 1'b0;
	logic [WEIGHT_W-1:0] cfg_wr_data  = '0;
	logic                event_valid  = 1'b0;
	logic                event_stall;
	in_item_t            event_item   = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	out_item_t           result_item;

	// Predicted block state
	logic [WEIGHT_W-1:0]      weight_q  = WEIGHT_RESET;
	logic signed [SAMP_W-1:0] right_cnt = '0;
	logic signed [SAMP_W-1:0] left_cnt  = '0;
	logic signed [FILT_W-1:0] right_ema = '0;
	logic signed [FILT_W-1:0] left_ema  = '0;
	logic signed [DIST_W-1:0] distance  = '0;

	// Speed results still owed by the block, oldest first
	out_item_t speed_q[$];

	int mismatches  = 0;
	int burst_left  = 0;
	int idle_cycles = 0;
	int stall_clock = 0;
	int items_sent  = 0;

	always #5 clk = ~clk;

	dual_quadrature_speed_filter u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.event_valid  (event_valid),
		.event_stall  (event_stall),
		.event_item   (event_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// One saturating count step.
	function automatic logic signed [SAMP_W-1:0] count_move(
		input logic signed [SAMP_W-1:0] c,
		input logic                     up
	);
		if (up)
			return (c == {1'b0, {(SAMP_W-1){1'b1}}}) ? c : c + SAMP_W'(1);
		return (c == {1'b1, {(SAMP_W-1){1'b0}}}) ? c : c - SAMP_W'(1);
	endfunction

	// Exponential filter, result in 1/256 count; floor shift, then clamp to 24 bits.
	function automatic logic signed [FILT_W-1:0] ema_update(
		input logic signed [SAMP_W-1:0] raw,
		input logic signed [FILT_W-1:0] old
	);
		longint w;
		longint v;
		// weight above 1.0 acts as exactly 1.0
		w = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : longint'(weight_q);
		v = w * raw * WEIGHT_ONE + (WEIGHT_ONE - w) * old;
		v = v >>> FRAC_BITS;
		if (v > longint'(FILT_MAX_V))
			v = longint'(FILT_MAX_V);
		if (v < longint'(FILT_MIN_V))
			v = longint'(FILT_MIN_V);
		return v[FILT_W-1:0];
	endfunction

	// Apply one accepted item to the predicted state; a tick owes one result.
	task automatic track_item(input in_item_t it);
		out_item_t exp;
		longint    avg;
		if (it.cmd == CMD_EDGE) begin
			// right: A flag first, B flag only when A is quiet
			if (it.pin_flags[PIN_RA])
				right_cnt = count_move(right_cnt, it.pin_levels[PIN_RB]);
			else if (it.pin_flags[PIN_RB])
				right_cnt = count_move(right_cnt, !it.pin_levels[PIN_RA]);
			// left runs mirrored
			if (it.pin_flags[PIN_LA])
				left_cnt = count_move(left_cnt, !it.pin_levels[PIN_LB]);
			else if (it.pin_flags[PIN_LB])
				left_cnt = count_move(left_cnt, it.pin_levels[PIN_LA]);
		end else begin
			// tick: flags and levels play no part
			left_ema  = ema_update(left_cnt, left_ema);
			right_ema = ema_update(right_cnt, right_ema);
			avg       = (longint'(left_ema) + longint'(right_ema)) >>> 1;
			distance  = DIST_W'(distance + avg);  // 48-bit wrap
			exp.left_sampled     = left_cnt;
			exp.right_sampled    = right_cnt;
			exp.filtered_average = avg[FILT_W-1:0];
			exp.distance_total   = distance;
			speed_q.push_back(exp);
			left_cnt  = '0;
			right_cnt = '0;
		end
	endtask

	// ------------------------------------------------------------------
	// Item driver
	// ------------------------------------------------------------------

	function automatic in_item_t make_item(input logic c, input logic [3:0] f,
		input logic [3:0] l);
		in_item_t it;
		it.cmd        = c;
		it.pin_flags  = f;
		it.pin_levels = l;
		return it;
	endfunction

	// Drive one item at the falling edge and hold it until accepted.
	// Items go out in bursts; a gap may open before each burst.
	// Every fourth block of 256 items runs with no gaps at all.
	task automatic send_item(input in_item_t it);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if ((items_sent / 256) % 4 == 0 || $urandom_range(0, 3) == 0)
				gap = 0;
			else
				gap = $urandom_range(1, 5);
			if (gap > 0) begin
				event_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		event_item  = it;
		event_valid = 1'b1;
		do @(posedge clk); while (event_stall);
		burst_left--;
		items_sent++;
		track_item(it);
	endtask

	// Stop sending and wait for every owed result, plus a few cycles since
	// edge items leave nothing in the queue to wait for.
	task automatic drain();
		@(negedge clk);
		event_valid = 1'b0;
		while (speed_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Weight writes only happen with the block idle.
	task automatic set_weight(input logic [WEIGHT_W-1:0] w);
		drain();
		@(negedge clk);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = w;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		weight_q  = w;
	endtask

	// A run of edge items followed by a tick. Biased runs keep both A flags
	// set with fixed B levels, so the counts build up in one direction.
	task automatic run_edges_then_tick(input int len, input bit biased);
		in_item_t it;
		logic     rdir;
		logic     ldir;
		rdir = 1'($urandom_range(0, 1));
		ldir = 1'($urandom_range(0, 1));
		for (int k = 0; k < len; k++) begin
			it = make_item(CMD_EDGE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
			if (biased) begin
				it.pin_flags[PIN_RA]  = 1'b1;
				it.pin_flags[PIN_LA]  = 1'b1;
				it.pin_levels[PIN_RB] = rdir;
				it.pin_levels[PIN_LB] = ldir;
			end
			send_item(it);
		end
		send_item(make_item(CMD_TICK, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15))));
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Direction rules for every flag/level case, field extremes, and ticks
	// with flags and levels that must be ignored. Runs at the reset weight.
	task automatic test_pin_rules();
		send_item(make_item(CMD_EDGE, 4'b0000, 4'b0000));  // no flags: no move
		send_item(make_item(CMD_EDGE, 4'b0000, 4'b1111));
		send_item(make_item(CMD_EDGE, 4'b0001, 4'b0000));  // right A, B low: down
		send_item(make_item(CMD_EDGE, 4'b0001, 4'b0010));  // right A, B high: up
		send_item(make_item(CMD_EDGE, 4'b0001, 4'b0010));
		send_item(make_item(CMD_EDGE, 4'b0010, 4'b0000));  // right B, A low: up
		send_item(make_item(CMD_EDGE, 4'b0010, 4'b0001));  // right B, A high: down
		send_item(make_item(CMD_EDGE, 4'b0011, 4'b0001));  // both: A flag wins
		send_item(make_item(CMD_TICK, 4'b1111, 4'b1111));
		send_item(make_item(CMD_EDGE, 4'b0100, 4'b0000));  // left A, B low: up
		send_item(make_item(CMD_EDGE, 4'b0100, 4'b1000));  // left A, B high: down
		send_item(make_item(CMD_EDGE, 4'b0100, 4'b0000));
		send_item(make_item(CMD_EDGE, 4'b1000, 4'b0000));  // left B, A low: down
		send_item(make_item(CMD_EDGE, 4'b1000, 4'b0100));  // left B, A high: up
		send_item(make_item(CMD_EDGE, 4'b1100, 4'b1100));  // both: A flag wins
		send_item(make_item(CMD_TICK, 4'b0000, 4'b0000));
		send_item(make_item(CMD_EDGE, 4'b1111, 4'b1111));
		send_item(make_item(CMD_EDGE, 4'b1111, 4'b0000));
		send_item(make_item(CMD_EDGE, 4'b1111, 4'b1010));
		send_item(make_item(CMD_TICK, 4'b0000, 4'b1111));
		send_item(make_item(CMD_TICK, 4'b1111, 4'b0000));  // counts already clear
		drain();
	endtask

	// Long one-direction runs on both counters; the ticks latch the counts.
	task automatic test_long_runs();
		logic [3:0] lv;
		// right climbs, left falls
		for (int k = 0; k < LONG_RUN; k++) begin
			lv = 4'($urandom_range(0, 15));
			lv[PIN_RB] = 1'b1;
			lv[PIN_LB] = 1'b1;
			send_item(make_item(CMD_EDGE, 4'b0101, lv));
		end
		send_item(make_item(CMD_TICK, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15))));
		// and the other way round
		for (int k = 0; k < LONG_RUN; k++) begin
			lv = 4'($urandom_range(0, 15));
			lv[PIN_RB] = 1'b0;
			lv[PIN_LB] = 1'b0;
			send_item(make_item(CMD_EDGE, 4'b0101, lv));
		end
		send_item(make_item(CMD_TICK, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15))));
		drain();
	endtask

	// Filter at the weight extremes, including values above 1.0.
	task automatic test_weight_settings();
		logic [WEIGHT_W-1:0] wlist[7];
		wlist = '{9'd0, 9'd256, 9'd257, 9'd511, 9'd1, 9'd255, 9'd128};
		foreach (wlist[i]) begin
			set_weight(wlist[i]);
			for (int s = 0; s < 3; s++)
				run_edges_then_tick($urandom_range(0, 10), 1'($urandom_range(0, 1)));
		end
		drain();
	endtask

	// Mostly edge runs ending in a tick, some lone random items; the weight
	// is rewritten now and then between phases.
	task automatic test_random_traffic();
		int start;
		int next_cfg;
		int choice;
		start    = items_sent;
		next_cfg = 50;
		while (items_sent - start < RANDOM_RUN) begin
			if (items_sent - start >= next_cfg) begin
				next_cfg += 50;
				case ($urandom_range(0, 3))
					0: set_weight(9'd0);
					1: set_weight(9'd256);
					2: set_weight(9'd511);
					default: set_weight(WEIGHT_W'($urandom_range(0, 511)));
				endcase
			end
			choice = $urandom_range(0, 9);
			if (choice == 0)
				send_item(make_item(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
					4'($urandom_range(0, 15))));
			else if (choice < 4)
				run_edges_then_tick($urandom_range(0, 40), 1'b1);
			else
				run_edges_then_tick($urandom_range(0, 8), 1'b0);
		end
		drain();
	endtask

	// ------------------------------------------------------------------
	// Result side: stall pattern, checker, watchdog
	// ------------------------------------------------------------------

	// Stall pattern steps through six modes in turn: none, sparse, periodic,
	// coin flip, long stretches, rare.
	always @(negedge clk) begin
		stall_clock <= stall_clock + 1;
		case ((stall_clock / 64) % 6)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 3) == 0);
			2: result_stall <= (stall_clock % 8 < 5);
			3: result_stall <= 1'($urandom_range(0, 1));
			4: result_stall <= (stall_clock % 32 < 20);
			default: result_stall <= ($urandom_range(0, 9) == 0);
		endcase
	end

	task automatic show_diff(input string field, input logic signed [63:0] want,
		input logic signed [63:0] got);
		$display("%0t %s mismatch: expected %0d actual %0d", $time, field, want, got);
		mismatches++;
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (speed_q.size() == 0) begin
				$display("%0t result with none owed: expected none actual %p",
					$time, result_item);
				mismatches++;
			end else begin
				want = speed_q.pop_front();
				if (want.left_sampled !== result_item.left_sampled)
					show_diff("left_sampled", want.left_sampled, result_item.left_sampled);
				if (want.right_sampled !== result_item.right_sampled)
					show_diff("right_sampled", want.right_sampled, result_item.right_sampled);
				if (want.filtered_average !== result_item.filtered_average)
					show_diff("filtered_average", want.filtered_average,
						result_item.filtered_average);
				if (want.distance_total !== result_item.distance_total)
					show_diff("distance_total", want.distance_total,
						result_item.distance_total);
			end
		end
		// watchdog: any handshake or weight write counts as progress
		if (!arst_n || cfg_wr_en || (event_valid && !event_stall) ||
			(result_valid && !result_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_pin_rules();
		test_long_runs();
		test_weight_settings();
		test_random_traffic();
		drain();
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
